// File: rtl/flow_delta_traffic_accounting_top_macros.svh
// ---------------------------------------------------------------------------
// flow delta traffic accounting assertion macros
// shared forms for the port checker
// ---------------------------------------------------------------------------
`ifndef FLOW_DELTA_TRAFFIC_ACCOUNTING_TOP_MACROS_SVH
`define FLOW_DELTA_TRAFFIC_ACCOUNTING_TOP_MACROS_SVH

// property checked outside reset
`define FDTA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define FDTA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fdta_pkg.sv
// ---------------------------------------------------------------------------
// fdta_pkg
// word types, entry types and codes of the flow delta traffic accounting block
// ---------------------------------------------------------------------------
package fdta_pkg;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_FORGET  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  localparam logic [1:0] KIND_CAT   = 2'd0;
  localparam logic [1:0] KIND_APP   = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic REG_TOP_COUNT = 1'b0;
  localparam logic [4:0] TOP_COUNT_RESET = 5'd8;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  flow_slot;
    logic [3:0]  app_slot;
    logic [3:0]  cat_slot;
    logic [63:0] tx_byte_total;
    logic [63:0] rx_byte_total;
    logic [31:0] tx_pkt_total;
    logic [31:0] rx_pkt_total;
    logic        is_new;
  } item_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  bucket_id;
    logic [63:0] sum_tx_bytes;
    logic [63:0] sum_rx_bytes;
    logic [31:0] sum_tx_pkts;
    logic [31:0] sum_rx_pkts;
    logic [31:0] flow_count;
    logic        last;
  } result_word_t;

  typedef struct packed {
    logic [63:0] tx_octets;
    logic [63:0] rx_octets;
    logic [31:0] tx_pkts;
    logic [31:0] rx_pkts;
  } flow_ent_t;

  typedef struct packed {
    logic [63:0] tx_octets;
    logic [63:0] rx_octets;
    logic [31:0] tx_pkts;
    logic [31:0] rx_pkts;
    logic [31:0] flows;
  } bkt_ent_t;

endpackage

// File: rtl/fdta_ram.sv
// ---------------------------------------------------------------------------
// fdta_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module fdta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fdta_acc.sv
// ---------------------------------------------------------------------------
// fdta_acc
// bucket accumulate: adds flow deltas and the new flow mark to one bucket
// ---------------------------------------------------------------------------
module fdta_acc import fdta_pkg::*; (
  input  bkt_ent_t  old_ent,
  input  logic      old_valid,
  input  flow_ent_t delta,
  input  logic      is_new,
  output bkt_ent_t  new_ent
);

  bkt_ent_t base;

  always_comb begin
    base = old_valid ? old_ent : '0;
    new_ent.tx_octets = base.tx_octets + delta.tx_octets;
    new_ent.rx_octets = base.rx_octets + delta.rx_octets;
    new_ent.tx_pkts   = base.tx_pkts + delta.tx_pkts;
    new_ent.rx_pkts   = base.rx_pkts + delta.rx_pkts;
    new_ent.flows     = base.flows + 32'(is_new);
  end

endmodule

// File: rtl/flow_delta_traffic_accounting_top.sv
// ---------------------------------------------------------------------------
// flow_delta_traffic_accounting_top
// per flow delta accounting into application and category buckets
// ---------------------------------------------------------------------------
// item channel (item_valid, item_stall, item) takes one command word at a time:
// observe, forget or sample. result channel (result_valid, result_stall,
// result) carries the sample report words, the final one with last set.
// observe reads the flow and bucket rams, then forms the delta and writes back.
// forget clears its flow slot as it is taken. sample scans the categories with
// a read state and a use state per slot, then runs one ranking pass over the
// application slots per reported or folded application on the shared key
// adder and compare, plus one final pass and a close in the finish state; a
// stalled receiver holds the sequencer whenever both the result register and
// the one word look-ahead register are full. after reset the flow ram is
// cleared, one slot a cycle, over all FLOW_SLOTS slots, with item_stall high;
// top_count returns to 8 and all buckets are empty. top_count is written
// through the apb port at address 0, where only paddr[2] is decoded. a new
// item is taken while the last report word still waits in the result register.
// ---------------------------------------------------------------------------
module flow_delta_traffic_accounting_top import fdta_pkg::*; #(
  parameter int FLOW_SLOTS = 64,
  parameter int APP_SLOTS  = 16,
  parameter int CAT_SLOTS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  item_word_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int FW  = $clog2(FLOW_SLOTS);
  localparam int FXW = (FW >= 6) ? FW + 1 : 7;
  localparam int AW  = $clog2(APP_SLOTS);
  localparam int CW  = $clog2(CAT_SLOTS);
  localparam int RKW = $clog2(APP_SLOTS + 1);

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_OBS     = 4'd2;
  localparam logic [3:0] S_CAT_RD  = 4'd3;
  localparam logic [3:0] S_CAT_USE = 4'd4;
  localparam logic [3:0] S_APP_RD  = 4'd5;
  localparam logic [3:0] S_APP_USE = 4'd6;
  localparam logic [3:0] S_APP_END = 4'd7;
  localparam logic [3:0] S_FIN     = 4'd8;

  logic [3:0] state;
  logic [4:0] top_count;
  item_word_t cur;

  logic [FW-1:0] init_ptr;
  logic [AW-1:0] app_idx;
  logic [CW-1:0] cat_idx;
  logic [APP_SLOTS-1:0] app_valid;
  logic [APP_SLOTS-1:0] picked;
  logic [CAT_SLOTS-1:0] cat_valid;
  logic [RKW-1:0] rank;

  logic          found;
  logic [AW-1:0] best_slot;
  bkt_ent_t      best_ent;
  logic [63:0]   best_key;
  logic          fold_any;
  bkt_ent_t      other;

  logic          pend_valid;
  result_word_t  pend;

  // apb port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_TOP_COUNT);
  assign prdata = (paddr[2] == REG_TOP_COUNT) ? {27'd0, top_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_RESET;
    end else if (cfg_we) begin
      top_count <= pwdata[4:0];
    end
  end

  // slot decode
  logic [FXW-1:0] f_ext, cf_ext;
  logic [5:0] a_ext, c_ext, ca_ext, cc_ext;
  logic item_fire, f_ok, cf_a_ok, cf_c_ok;

  assign item_stall = (state != S_IDLE);
  assign item_fire  = item_valid && !item_stall;
  assign f_ext  = FXW'(item.flow_slot);
  assign a_ext  = 6'(item.app_slot);
  assign c_ext  = 6'(item.cat_slot);
  assign cf_ext = FXW'(cur.flow_slot);
  assign ca_ext = 6'(cur.app_slot);
  assign cc_ext = 6'(cur.cat_slot);
  assign f_ok    = f_ext < FXW'(FLOW_SLOTS);
  assign cf_a_ok = ca_ext < 6'(APP_SLOTS);
  assign cf_c_ok = cc_ext < 6'(CAT_SLOTS);

  // memories
  logic      flow_we;
  logic [FW-1:0] flow_waddr, flow_raddr;
  flow_ent_t flow_wdata, flow_rdata;
  logic      app_we, cat_we;
  logic [AW-1:0] app_raddr;
  logic [CW-1:0] cat_raddr;
  bkt_ent_t  app_wdata, app_rdata, cat_wdata, cat_rdata;

  fdta_ram #(.WIDTH($bits(flow_ent_t)), .DEPTH(FLOW_SLOTS)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
    .raddr(flow_raddr), .rdata(flow_rdata)
  );

  fdta_ram #(.WIDTH($bits(bkt_ent_t)), .DEPTH(APP_SLOTS)) u_app_ram (
    .clk(clk), .we(app_we), .waddr(ca_ext[AW-1:0]), .wdata(app_wdata),
    .raddr(app_raddr), .rdata(app_rdata)
  );

  fdta_ram #(.WIDTH($bits(bkt_ent_t)), .DEPTH(CAT_SLOTS)) u_cat_ram (
    .clk(clk), .we(cat_we), .waddr(cc_ext[CW-1:0]), .wdata(cat_wdata),
    .raddr(cat_raddr), .rdata(cat_rdata)
  );

  // deltas against the stored totals
  flow_ent_t delta, new_tot;
  always_comb begin
    new_tot.tx_octets = cur.tx_byte_total;
    new_tot.rx_octets = cur.rx_byte_total;
    new_tot.tx_pkts   = cur.tx_pkt_total;
    new_tot.rx_pkts   = cur.rx_pkt_total;
    delta.tx_octets = (new_tot.tx_octets >= flow_rdata.tx_octets) ?
                      new_tot.tx_octets - flow_rdata.tx_octets : new_tot.tx_octets;
    delta.rx_octets = (new_tot.rx_octets >= flow_rdata.rx_octets) ?
                      new_tot.rx_octets - flow_rdata.rx_octets : new_tot.rx_octets;
    delta.tx_pkts   = (new_tot.tx_pkts >= flow_rdata.tx_pkts) ?
                      new_tot.tx_pkts - flow_rdata.tx_pkts : new_tot.tx_pkts;
    delta.rx_pkts   = (new_tot.rx_pkts >= flow_rdata.rx_pkts) ?
                      new_tot.rx_pkts - flow_rdata.rx_pkts : new_tot.rx_pkts;
  end

  fdta_acc u_app_acc (
    .old_ent(app_rdata), .old_valid(app_valid[ca_ext[AW-1:0]]), .delta(delta),
    .is_new(cur.is_new), .new_ent(app_wdata)
  );

  fdta_acc u_cat_acc (
    .old_ent(cat_rdata), .old_valid(cat_valid[cc_ext[CW-1:0]]), .delta(delta),
    .is_new(cur.is_new), .new_ent(cat_wdata)
  );

  always_comb begin
    flow_we    = 1'b0;
    flow_waddr = cf_ext[FW-1:0];
    flow_wdata = new_tot;
    priority if (state == S_INIT) begin
      flow_we    = 1'b1;
      flow_waddr = init_ptr;
      flow_wdata = '0;
    end else if (item_fire && f_ok && item.command == CMD_FORGET) begin
      flow_we    = 1'b1;
      flow_waddr = f_ext[FW-1:0];
      flow_wdata = '0;
    end else if (state == S_OBS) begin
      flow_we = 1'b1;
    end
  end

  assign flow_raddr = f_ext[FW-1:0];
  assign app_raddr  = (state == S_IDLE) ? a_ext[AW-1:0] : app_idx;
  assign cat_raddr  = (state == S_IDLE) ? c_ext[CW-1:0] : cat_idx;
  assign app_we     = (state == S_OBS) && cf_a_ok;
  assign cat_we     = (state == S_OBS) && cf_c_ok;

  // shared ranking unit: key add and compare
  logic [63:0] scan_key;
  logic        scan_take, cand;
  assign scan_key  = app_rdata.tx_octets + app_rdata.rx_octets;
  assign cand      = app_valid[app_idx] && !picked[app_idx];
  assign scan_take = cand && (!found || scan_key > best_key);

  // report words
  logic can_put, out_free;
  result_word_t cat_word, app_word, other_word, empty_word, pend_last;
  assign out_free = !result_valid || !result_stall;
  assign can_put  = !pend_valid || out_free;

  always_comb begin
    cat_word = '{kind: KIND_CAT, bucket_id: 4'(cat_idx),
                 sum_tx_bytes: cat_rdata.tx_octets, sum_rx_bytes: cat_rdata.rx_octets,
                 sum_tx_pkts: cat_rdata.tx_pkts, sum_rx_pkts: cat_rdata.rx_pkts,
                 flow_count: cat_rdata.flows, last: 1'b0};
    app_word = '{kind: KIND_APP, bucket_id: 4'(best_slot),
                 sum_tx_bytes: best_ent.tx_octets, sum_rx_bytes: best_ent.rx_octets,
                 sum_tx_pkts: best_ent.tx_pkts, sum_rx_pkts: best_ent.rx_pkts,
                 flow_count: best_ent.flows, last: 1'b0};
    other_word = '{kind: KIND_OTHER, bucket_id: 4'd0,
                   sum_tx_bytes: other.tx_octets, sum_rx_bytes: other.rx_octets,
                   sum_tx_pkts: other.tx_pkts, sum_rx_pkts: other.rx_pkts,
                   flow_count: other.flows, last: 1'b0};
    empty_word = '0;
    empty_word.kind = KIND_EMPTY;
    empty_word.last = 1'b1;
    pend_last = pend;
    pend_last.last = 1'b1;
  end

  logic         put_fire, fin_fire;
  result_word_t put_word, fin_word;
  logic         app_report;
  assign app_report = 32'(rank) < 32'(top_count);

  always_comb begin
    put_fire = 1'b0;
    put_word = cat_word;
    fin_fire = 1'b0;
    fin_word = empty_word;
    unique case (state)
      S_CAT_USE: begin
        put_fire = cat_valid[cat_idx] && can_put;
      end
      S_APP_END: begin
        put_fire = found && app_report && can_put;
        put_word = app_word;
      end
      S_FIN: begin
        if (fold_any) begin
          put_fire = can_put;
          put_word = other_word;
        end else begin
          fin_fire = out_free;
          fin_word = pend_valid ? pend_last : empty_word;
        end
      end
      default: begin
      end
    endcase
  end

  // result register and look-ahead word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      if (put_fire) begin
        pend       <= put_word;
        pend_valid <= 1'b1;
      end else if (fin_fire) begin
        pend_valid <= 1'b0;
      end
      if ((put_fire && pend_valid) || fin_fire) begin
        result       <= fin_fire ? fin_word : pend;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_ptr   <= '0;
      app_valid  <= '0;
      cat_valid  <= '0;
      picked     <= '0;
      found      <= 1'b0;
      fold_any   <= 1'b0;
      rank       <= '0;
      app_idx    <= '0;
      cat_idx    <= '0;
    end else begin
      unique case (state)
        S_INIT: begin
          init_ptr <= init_ptr + 1'b1;
          if (init_ptr == FW'(FLOW_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_fire) begin
            cur <= item;
            if (item.command == CMD_SAMPLE) begin
              cat_idx    <= '0;
              app_idx    <= '0;
              picked     <= '0;
              found      <= 1'b0;
              fold_any   <= 1'b0;
              other      <= '0;
              rank       <= '0;
              state      <= S_CAT_RD;
            end else if (item.command == CMD_OBSERVE && f_ok) begin
              state <= S_OBS;
            end
          end
        end
        S_OBS: begin
          if (cf_a_ok) begin
            app_valid[ca_ext[AW-1:0]] <= 1'b1;
          end
          if (cf_c_ok) begin
            cat_valid[cc_ext[CW-1:0]] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_CAT_RD: begin
          state <= S_CAT_USE;
        end
        S_CAT_USE: begin
          if (!cat_valid[cat_idx] || can_put) begin
            if (cat_idx == CW'(CAT_SLOTS - 1)) begin
              state <= S_APP_RD;
            end else begin
              cat_idx <= cat_idx + 1'b1;
              state   <= S_CAT_RD;
            end
          end
        end
        S_APP_RD: begin
          state <= S_APP_USE;
        end
        S_APP_USE: begin
          if (scan_take) begin
            found     <= 1'b1;
            best_slot <= app_idx;
            best_ent  <= app_rdata;
            best_key  <= scan_key;
          end
          if (app_idx == AW'(APP_SLOTS - 1)) begin
            state <= S_APP_END;
          end else begin
            app_idx <= app_idx + 1'b1;
            state   <= S_APP_RD;
          end
        end
        S_APP_END: begin
          priority if (!found) begin
            state <= S_FIN;
          end else if (!app_report || can_put) begin
            if (!app_report) begin
              fold_any        <= 1'b1;
              other.tx_octets <= other.tx_octets + best_ent.tx_octets;
              other.rx_octets <= other.rx_octets + best_ent.rx_octets;
              other.tx_pkts   <= other.tx_pkts + best_ent.tx_pkts;
              other.rx_pkts   <= other.rx_pkts + best_ent.rx_pkts;
              other.flows     <= other.flows + best_ent.flows;
            end
            picked[best_slot] <= 1'b1;
            rank    <= rank + 1'b1;
            found   <= 1'b0;
            app_idx <= '0;
            state   <= S_APP_RD;
          end
        end
        S_FIN: begin
          if (fold_any && can_put) begin
            fold_any <= 1'b0;
          end
          if (fin_fire) begin
            app_valid <= '0;
            cat_valid <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/fdta_chk.sv
// ---------------------------------------------------------------------------
// fdta_chk
// port level checks of the flow delta traffic accounting block
// ---------------------------------------------------------------------------
`include "flow_delta_traffic_accounting_top_macros.svh"

module fdta_chk import fdta_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         item_valid,
  input logic         item_stall,
  input item_word_t   item,
  input logic         result_valid,
  input logic         result_stall,
  input result_word_t result,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  `FDTA_ASSERT(a_hold, clk, rst,
    result_valid && result_stall |=> result_valid && $stable(result),
    "result word changed while stalled")
  `FDTA_ASSERT_ALWAYS(a_init_stall, clk, rst |=> item_stall,
    "item taken during flow table clear")
  `FDTA_ASSERT(a_empty_last, clk, rst,
    result_valid && result.kind == KIND_EMPTY |-> result.last,
    "empty snapshot without last")
  `FDTA_ASSERT(a_sample_busy, clk, rst,
    item_valid && !item_stall && item.command == CMD_SAMPLE |=> item_stall,
    "item taken during sample")

endmodule

bind flow_delta_traffic_accounting_top fdta_chk u_fdta_chk (.*);

// File: verif/flow_delta_traffic_accounting_top_tb.sv
// ---------------------------------------------------------------------------
// flow_delta_traffic_accounting_top_tb
// drives observe, forget, sample and unused command words into the accounting block, keeps
// its own flow and bucket tables to predict every report word, and checks
// each result word field by field under random idling and receiver stalls
// ---------------------------------------------------------------------------
module flow_delta_traffic_accounting_top_tb;
  import fdta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFLOW = 64;
  localparam int NBKT = 16;
  localparam int IDLE_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_stall;
  item_word_t   item;
  logic         result_valid;
  logic         result_stall;
  result_word_t result;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  flow_delta_traffic_accounting_top u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  flow_ent_t    flow_tab[NFLOW];
  bkt_ent_t     app_tab[NBKT];
  bkt_ent_t     cat_tab[NBKT];
  bit           app_used[NBKT];
  bit           cat_used[NBKT];
  logic [4:0]   top_n;
  result_word_t report_q[$];

  int  send_idle_pct;
  int  stall_pct;
  int  hold_cycles;
  int  idle_cycles;
  int  fails;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_buckets();
    for (int i = 0; i < NBKT; i++) begin
      app_tab[i] = '0;
      cat_tab[i] = '0;
      app_used[i] = 1'b0;
      cat_used[i] = 1'b0;
    end
  endfunction

  function automatic void push_report(logic [1:0] k, logic [3:0] id, bkt_ent_t b);
    result_word_t r;
    r.kind = k;
    r.bucket_id = id;
    r.sum_tx_bytes = b.tx_octets;
    r.sum_rx_bytes = b.rx_octets;
    r.sum_tx_pkts = b.tx_pkts;
    r.sum_rx_pkts = b.rx_pkts;
    r.flow_count = b.flows;
    r.last = 1'b0;
    report_q.insert(report_q.size(), r);
  endfunction

  function automatic bkt_ent_t add_bucket(bkt_ent_t b, bkt_ent_t d);
    b.tx_octets += d.tx_octets;
    b.rx_octets += d.rx_octets;
    b.tx_pkts += d.tx_pkts;
    b.rx_pkts += d.rx_pkts;
    b.flows += d.flows;
    return b;
  endfunction

  function automatic void predict_sample();
    int order[$];
    int n_before;
    int pos;
    bit folded;
    bkt_ent_t other;
    logic [63:0] key;
    n_before = report_q.size();
    other = '0;
    folded = 1'b0;
    for (int i = 0; i < NBKT; i++)
      if (cat_used[i]) push_report(KIND_CAT, 4'(i), cat_tab[i]);
    for (int i = 0; i < NBKT; i++) begin
      if (!app_used[i]) continue;
      key = app_tab[i].tx_octets + app_tab[i].rx_octets;
      pos = order.size();
      while (pos > 0 && key > 64'(app_tab[order[pos-1]].tx_octets
                                 + app_tab[order[pos-1]].rx_octets))
        pos--;
      order.insert(pos, i);
    end
    foreach (order[i]) begin
      if (i < top_n) push_report(KIND_APP, 4'(order[i]), app_tab[order[i]]);
      else begin
        folded = 1'b1;
        other = add_bucket(other, app_tab[order[i]]);
      end
    end
    if (folded) push_report(KIND_OTHER, 4'd0, other);
    if (report_q.size() == n_before) push_report(KIND_EMPTY, 4'd0, '0);
    report_q[report_q.size()-1].last = 1'b1;
    clear_buckets();
  endfunction

  function automatic void predict_word(item_word_t w);
    bkt_ent_t d;
    flow_ent_t f;
    case (w.command)
      CMD_SAMPLE: predict_sample();
      CMD_FORGET: flow_tab[w.flow_slot] = '0;
      CMD_OBSERVE: begin
        f = flow_tab[w.flow_slot];
        d.tx_octets = w.tx_byte_total >= f.tx_octets ?
                      w.tx_byte_total - f.tx_octets : w.tx_byte_total;
        d.rx_octets = w.rx_byte_total >= f.rx_octets ?
                      w.rx_byte_total - f.rx_octets : w.rx_byte_total;
        d.tx_pkts = w.tx_pkt_total >= f.tx_pkts ?
                    w.tx_pkt_total - f.tx_pkts : w.tx_pkt_total;
        d.rx_pkts = w.rx_pkt_total >= f.rx_pkts ?
                    w.rx_pkt_total - f.rx_pkts : w.rx_pkt_total;
        d.flows = 32'(w.is_new);
        flow_tab[w.flow_slot] = '{w.tx_byte_total, w.rx_byte_total,
                                  w.tx_pkt_total, w.rx_pkt_total};
        app_tab[w.app_slot] = add_bucket(app_tab[w.app_slot], d);
        cat_tab[w.cat_slot] = add_bucket(cat_tab[w.cat_slot], d);
        app_used[w.app_slot] = 1'b1;
        cat_used[w.cat_slot] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    result_word_t exp_w;
    if (!rst && result_valid && !result_stall) begin
      if (report_q.size() == 0) begin
        $error("result word with nothing expected: %p", result);
        fails++;
      end else begin
        exp_w = report_q.pop_front();
        if (result.kind !== exp_w.kind) begin
          $error("kind exp %0d got %0d", exp_w.kind, result.kind); fails++;
        end
        if (result.bucket_id !== exp_w.bucket_id) begin
          $error("bucket_id exp %0d got %0d", exp_w.bucket_id, result.bucket_id);
          fails++;
        end
        if (result.sum_tx_bytes !== exp_w.sum_tx_bytes) begin
          $error("sum_tx_bytes exp %h got %h", exp_w.sum_tx_bytes, result.sum_tx_bytes);
          fails++;
        end
        if (result.sum_rx_bytes !== exp_w.sum_rx_bytes) begin
          $error("sum_rx_bytes exp %h got %h", exp_w.sum_rx_bytes, result.sum_rx_bytes);
          fails++;
        end
        if (result.sum_tx_pkts !== exp_w.sum_tx_pkts) begin
          $error("sum_tx_pkts exp %h got %h", exp_w.sum_tx_pkts, result.sum_tx_pkts);
          fails++;
        end
        if (result.sum_rx_pkts !== exp_w.sum_rx_pkts) begin
          $error("sum_rx_pkts exp %h got %h", exp_w.sum_rx_pkts, result.sum_rx_pkts);
          fails++;
        end
        if (result.flow_count !== exp_w.flow_count) begin
          $error("flow_count exp %h got %h", exp_w.flow_count, result.flow_count);
          fails++;
        end
        if (result.last !== exp_w.last) begin
          $error("last exp %0d got %0d", exp_w.last, result.last); fails++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays up after acceptance until the next word or a drain drops it
  task automatic send_word(item_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_word(w);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_top(logic [4:0] v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'd0; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    top_n = v;
  endtask

  function automatic item_word_t rand_word(logic [1:0] cmd, int nflow);
    item_word_t w;
    w.command = cmd;
    w.flow_slot = 6'($urandom_range(nflow - 1));
    w.app_slot = 4'($urandom_range(15));
    w.cat_slot = 4'($urandom_range(15));
    case ($urandom_range(3))
      0: begin
        w.tx_byte_total = {$urandom, $urandom};
        w.rx_byte_total = {$urandom, $urandom};
      end
      1: begin
        w.tx_byte_total = 64'($urandom_range(5000));
        w.rx_byte_total = 64'($urandom_range(5000));
      end
      default: begin
        w.tx_byte_total = flow_tab[w.flow_slot].tx_octets + $urandom_range(3000);
        w.rx_byte_total = flow_tab[w.flow_slot].rx_octets + $urandom_range(3000);
      end
    endcase
    w.tx_pkt_total = $urandom_range(1) ? $urandom :
                     flow_tab[w.flow_slot].tx_pkts + $urandom_range(9);
    w.rx_pkt_total = $urandom_range(1) ? $urandom :
                     flow_tab[w.flow_slot].rx_pkts + $urandom_range(9);
    w.is_new = 1'($urandom_range(1));
    return w;
  endfunction

  function automatic item_word_t obs(int f, int a, int c, logic [63:0] tb,
                                     logic [63:0] rb, logic [31:0] tp,
                                     logic [31:0] rp, bit nw);
    item_word_t w;
    w = '{CMD_OBSERVE, 6'(f), 4'(a), 4'(c), tb, rb, tp, rp, nw};
    return w;
  endfunction

  task automatic sample_now();
    item_word_t w;
    w = rand_word(CMD_SAMPLE, NFLOW);
    send_word(w);
  endtask

  task automatic test_directed();
    item_word_t w;
    sample_now();
    send_word(obs(0, 0, 0, '1, '1, '1, '1, 1));
    send_word(obs(63, 15, 15, 64'd100, 64'd200, 32'd3, 32'd4, 0));
    send_word(obs(63, 15, 15, 64'd50, 64'd300, 32'd1, 32'd9, 1));
    send_word(obs(0, 3, 15, 64'd5, '1, 32'd0, '1, 1));
    send_word(obs(5, 7, 2, 64'd10, 64'd0, 32'd1, 32'd0, 0));
    send_word(obs(6, 8, 2, 64'd0, 64'd10, 32'd0, 32'd1, 0));
    sample_now();
    send_word(obs(9, 4, 1, 64'd1000, 64'd0, 32'd5, 32'd0, 1));
    w = rand_word(CMD_FORGET, NFLOW);
    w.flow_slot = 6'd9;
    send_word(w);
    send_word(obs(9, 4, 1, 64'd400, 64'd0, 32'd2, 32'd0, 1));
    w = rand_word(2'd3, NFLOW);
    send_word(w);
    sample_now();
  endtask

  task automatic test_top_count(logic [4:0] v, int words);
    write_top(v);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(9) == 0) send_word(rand_word(CMD_FORGET, 12));
      else if ($urandom_range(29) == 0) send_word(rand_word(2'd3, 12));
      else send_word(rand_word(CMD_OBSERVE, 12));
    end
    sample_now();
  endtask

  task automatic test_random(int words);
    item_word_t w;
    for (int i = 0; i < words; i++) begin
      case ($urandom_range(19))
        0, 1: w = rand_word(CMD_SAMPLE, NFLOW);
        2:    w = rand_word(CMD_FORGET, 16);
        3:    w = rand_word(2'd3, NFLOW);
        default: w = rand_word(CMD_OBSERVE, ($urandom_range(3) == 0) ? NFLOW : 16);
      endcase
      send_word(w);
    end
    sample_now();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 6; i++) send_word(rand_word(CMD_OBSERVE, 16));
      sample_now();
    end
    hold_cycles <= 600;
    for (int i = 0; i < 8; i++) begin
      send_word(rand_word(CMD_OBSERVE, 16));
      sample_now();
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    fails = 0;
    top_n = TOP_COUNT_RESET;
    for (int i = 0; i < NFLOW; i++) flow_tab[i] = '0;
    clear_buckets();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    send_idle_pct = 54;
    test_top_count(5'd0, 12);
    stall_pct = 54;
    send_idle_pct = 0;
    test_top_count(5'd16, 12);
    send_idle_pct = 23;
    stall_pct = 23;
    test_top_count(5'd31, 8);
    test_top_count(5'd3, 12);
    send_idle_pct = 54;
    stall_pct = 0;
    test_random(20);
    send_idle_pct = 0;
    stall_pct = 54;
    test_random(20);
    send_idle_pct = 23;
    stall_pct = 23;
    test_random(20);
    test_backpressure();
    write_top(TOP_COUNT_RESET);
    test_random(10);
    drain();
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
